[rtl/vgrt_pkg.sv]
`default_nettype none
package vgrt_pkg;

	localparam int FRAC    = 16;
	localparam int POS_W   = 24;
	localparam int DIR_W   = 16;
	localparam int DIST_W  = 24;
	localparam int VOX_W   = 11;
	localparam int Q_W     = FRAC + 1;
	localparam int SQ_W    = 2 * DIR_W;
	localparam int SQRT_IW = SQ_W + 16;
	localparam int LEN_W   = SQRT_IW / 2;
	localparam int DIV_NW  = DIR_W + FRAC + 8;
	localparam int DIV_DW  = 24;
	localparam int MUL_W   = 24;
	localparam int PROD_W  = 2 * MUL_W;

	localparam logic [DIST_W-1:0] DMAX = '1;
	localparam logic [Q_W-1:0]    ONE  = Q_W'(1) << FRAC;
	localparam logic [DIST_W-1:0] MAXD_RESET = 24'd6553600;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_CAST  = 1'b1;

	typedef logic [1:0] axis_t;
	localparam axis_t AXIS_X = 2'd0;
	localparam axis_t AXIS_Y = 2'd1;
	localparam axis_t AXIS_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_ZCHK, ST_SQRT_GO, ST_SQRT_RUN,
		ST_DQ_GO, ST_DQ_RUN, ST_DD_GO, ST_DD_RUN, ST_SIDE_MUL, ST_SIDE_SET,
		ST_T0, ST_STEP, ST_RD, ST_TST, ST_HP_MUL, ST_HP_ADD, ST_HIT, ST_MISS
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CLEAR, OP_WRITE, OP_LOAD, OP_MUL_SQ, OP_ACC_SQ, OP_SQRT_GO,
		OP_SET_LEN, OP_DIVQ_GO, OP_SET_Q, OP_DIVD_GO, OP_SET_D, OP_MUL_SIDE,
		OP_SET_SIDE, OP_STEP, OP_MUL_HP, OP_SET_HP, OP_OUT_HIT, OP_OUT_MISS
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		axis_t  axis;
	} cmd_t;

	typedef struct packed {
		logic sq_zero;
		logic sqrt_done;
		logic div_done;
		logic quo_zero;
		logic clr_last;
		logic reached;
		logic solid;
	} status_t;

endpackage
`default_nettype wire

[rtl/voxel_grid_ray_traversal.sv]
`default_nettype none
// Voxel grid ray traversal. The block holds a cubic occupancy grid of one bit per
// voxel and walks rays through it cell by cell. A request is taken at a clock edge
// with start high and busy low; req_type 0 writes one voxel's occupancy bit, and
// req_type 1 casts a ray from a fixed-point origin along the negated, normalized
// direction, skipping the voxel that holds the origin. Every request gives exactly
// one result, shown for one cycle with done high. The receiver cannot stall, so it
// must take the result in that cycle. After reset the block clears the grid, one
// voxel per cycle, and stays busy until every voxel is cleared. A write request
// is done at the edge that takes it, and its result appears in the next cycle. A
// cast request first runs a setup, most of it in the shared divider that forms
// each axis component and its step length, plus a square root, and then walks
// the grid, each step passing through the step, read and test states, because
// every step reads the occupancy memory through its registered read port. A walk
// ends at the first solid voxel or first boundary at or beyond max_distance. The
// max_distance register may be written at any time that no request is in flight; cfg_ready is always high.
module voxel_grid_ray_traversal
	import vgrt_pkg::*;
#(
	parameter int GRID_BITS = 5
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	output logic                          done,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic        [DIST_W-1:0] cfg_data,
	input  wire logic                     req_type,
	input  wire logic        [4:0]        voxel_x,
	input  wire logic        [4:0]        voxel_y,
	input  wire logic        [4:0]        voxel_z,
	input  wire logic                     solid,
	input  wire logic signed [POS_W-1:0]  origin_x,
	input  wire logic signed [POS_W-1:0]  origin_y,
	input  wire logic signed [POS_W-1:0]  origin_z,
	input  wire logic signed [DIR_W-1:0]  dir_x,
	input  wire logic signed [DIR_W-1:0]  dir_y,
	input  wire logic signed [DIR_W-1:0]  dir_z,
	output logic                          hit,
	output logic             [4:0]        block_x,
	output logic             [4:0]        block_y,
	output logic             [4:0]        block_z,
	output logic signed      [1:0]        normal_x,
	output logic signed      [1:0]        normal_y,
	output logic signed      [1:0]        normal_z,
	output logic             [DIST_W-1:0] distance,
	output logic signed      [POS_W-1:0]  hit_pos_x,
	output logic signed      [POS_W-1:0]  hit_pos_y,
	output logic signed      [POS_W-1:0]  hit_pos_z
);
	cmd_t    cmd;
	status_t st;

	// The register is taken in any cycle, including during the clearing pass.
	assign cfg_ready = 1'b1;

	// The controller sequences setup, the cell walk and the result.
	vgrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.st       (st),
		.busy     (busy),
		.done     (done),
		.cmd      (cmd)
	);

	// The datapath holds the grid memory, the ray state and the arithmetic units.
	vgrt_dpath #(
		.GRID_BITS (GRID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.solid     (solid),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.hit       (hit),
		.block_x   (block_x),
		.block_y   (block_y),
		.block_z   (block_z),
		.normal_x  (normal_x),
		.normal_y  (normal_y),
		.normal_z  (normal_z),
		.distance  (distance),
		.hit_pos_x (hit_pos_x),
		.hit_pos_y (hit_pos_y),
		.hit_pos_z (hit_pos_z)
	);
endmodule
`default_nettype wire

[rtl/vgrt_div.sv]
`default_nettype none
module vgrt_div
	import vgrt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              go,
	input  wire logic [DIV_NW-1:0] num,
	input  wire logic [DIV_DW-1:0] den,
	output logic                   done,
	output logic      [DIV_NW-1:0] quo
);
	// Restoring division, one quotient bit per cycle.
	localparam int CNT_W = $clog2(DIV_NW);

	logic              busy_q, done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q, den_q;
	logic [DIV_DW:0]   rem_sh, rem_nxt;
	logic              ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_NW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_nxt = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NW-2:0], ge};
			rem_q <= rem_nxt[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

[rtl/vgrt_sqrt.sv]
`default_nettype none
module vgrt_sqrt
	import vgrt_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire logic [SQRT_IW-1:0] val,
	output logic                    done,
	output logic      [LEN_W-1:0]   root
);
	// Digit-by-digit integer square root, one root bit per cycle.
	localparam int CNT_W = $clog2(LEN_W);

	logic               busy_q, done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SQRT_IW-1:0] v_q;
	logic [LEN_W-1:0]   root_q;
	logic [LEN_W:0]     rem_q;
	logic [LEN_W+2:0]   rem_sh, trial, rem_nxt;
	logic               ge;

	always_comb begin
		rem_sh  = {rem_q, v_q[SQRT_IW-1:SQRT_IW-2]};
		trial   = {1'b0, root_q, 2'b01};
		ge      = rem_sh >= trial;
		rem_nxt = ge ? (rem_sh - trial) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(LEN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			v_q    <= val;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			v_q    <= v_q << 2;
			root_q <= {root_q[LEN_W-2:0], ge};
			rem_q  <= rem_nxt[LEN_W:0];
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

[rtl/vgrt_dpath.sv]
`default_nettype none
module vgrt_dpath
	import vgrt_pkg::*;
#(
	parameter int GRID_BITS = 5
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output status_t                       st,
	input  wire logic                     cfg_valid,
	input  wire logic        [DIST_W-1:0] cfg_data,
	input  wire logic        [4:0]        voxel_x,
	input  wire logic        [4:0]        voxel_y,
	input  wire logic        [4:0]        voxel_z,
	input  wire logic                     solid,
	input  wire logic signed [POS_W-1:0]  origin_x,
	input  wire logic signed [POS_W-1:0]  origin_y,
	input  wire logic signed [POS_W-1:0]  origin_z,
	input  wire logic signed [DIR_W-1:0]  dir_x,
	input  wire logic signed [DIR_W-1:0]  dir_y,
	input  wire logic signed [DIR_W-1:0]  dir_z,
	output logic                          hit,
	output logic             [4:0]        block_x,
	output logic             [4:0]        block_y,
	output logic             [4:0]        block_z,
	output logic signed      [1:0]        normal_x,
	output logic signed      [1:0]        normal_y,
	output logic signed      [1:0]        normal_z,
	output logic             [DIST_W-1:0] distance,
	output logic signed      [POS_W-1:0]  hit_pos_x,
	output logic signed      [POS_W-1:0]  hit_pos_y,
	output logic signed      [POS_W-1:0]  hit_pos_z
);
	localparam int ADDR_W = 3 * GRID_BITS;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam logic signed [POS_W+2:0] SAT_HI = (POS_W+3)'(8388607);
	localparam logic signed [POS_W+2:0] SAT_LO = -(POS_W+3)'(8388608);

	// Occupancy memory with registered read.
	logic              grid_mem [DEPTH];
	logic              mem_we, mem_wd, rd_q;
	logic [ADDR_W-1:0] mem_wa, rd_addr, clr_q, wr_addr;
	logic [7:0]        wx8, wy8, wz8;
	logic              wr_ok;

	logic [DIST_W-1:0] max_q;

	// Ray state.
	logic signed [POS_W-1:0] org_q   [3];
	logic [DIR_W-1:0]        dmag_q  [3];
	logic                    dpos_q  [3];
	logic                    dneg_q  [3];
	logic                    npos_q  [3];
	logic [Q_W-1:0]          q_q     [3];
	logic [DIST_W-1:0]       delta_q [3];
	logic [DIST_W-1:0]       side_q  [3];
	logic signed [VOX_W-1:0] vox_q   [3];
	logic [SQ_W-1:0]         sq_q;
	logic [LEN_W-1:0]        len_q;
	logic [DIST_W-1:0]       trav_q;
	axis_t                   last_ax_q;
	logic [PROD_W-1:0]       prod_q;

	logic [MUL_W-1:0]        mul_a, mul_b;
	logic                    div_go, div_done, sqrt_done;
	logic [DIV_NW-1:0]       div_num, div_quo;
	logic [DIV_DW-1:0]       div_den;
	logic [LEN_W-1:0]        sqrt_root;
	logic [Q_W-1:0]          frac_sel;
	axis_t                   step_ax;
	logic                    ingrid;

	logic [FRAC+9:0]         hp_sh;
	logic signed [POS_W+2:0] hp_sum;
	logic signed [POS_W-1:0] hp_val;
	logic [DIST_W:0]         side_sp;

	logic signed [POS_W-1:0] org_in [3];
	logic signed [DIR_W-1:0] dir_in [3];

	assign org_in[0] = origin_x;
	assign org_in[1] = origin_y;
	assign org_in[2] = origin_z;
	assign dir_in[0] = dir_x;
	assign dir_in[1] = dir_y;
	assign dir_in[2] = dir_z;

	// Write requests with a coordinate outside the grid are dropped.
	assign wx8     = 8'(voxel_x);
	assign wy8     = 8'(voxel_y);
	assign wz8     = 8'(voxel_z);
	assign wr_ok   = ((wx8 >> GRID_BITS) == 8'd0) && ((wy8 >> GRID_BITS) == 8'd0)
		&& ((wz8 >> GRID_BITS) == 8'd0);
	assign wr_addr = {wx8[GRID_BITS-1:0], wy8[GRID_BITS-1:0], wz8[GRID_BITS-1:0]};

	assign mem_we  = (cmd.op == OP_CLEAR) || ((cmd.op == OP_WRITE) && wr_ok);
	assign mem_wa  = (cmd.op == OP_CLEAR) ? clr_q : wr_addr;
	assign mem_wd  = (cmd.op == OP_CLEAR) ? 1'b0 : solid;
	assign rd_addr = {vox_q[0][GRID_BITS-1:0], vox_q[1][GRID_BITS-1:0],
		vox_q[2][GRID_BITS-1:0]};
	assign ingrid  = (vox_q[0][VOX_W-1:GRID_BITS] == '0)
		&& (vox_q[1][VOX_W-1:GRID_BITS] == '0)
		&& (vox_q[2][VOX_W-1:GRID_BITS] == '0);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
		rd_q <= grid_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			max_q <= MAXD_RESET;
		end else begin
			if (cmd.op == OP_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
		end
	end

	// Boundary distance within the current cell along the selected axis.
	assign frac_sel = npos_q[cmd.axis] ? (ONE - Q_W'(org_q[cmd.axis][FRAC-1:0]))
		: Q_W'(org_q[cmd.axis][FRAC-1:0]);

	// Nearest boundary wins; ties go to z, then y.
	always_comb begin
		if (side_q[0] < side_q[1]) begin
			step_ax = (side_q[0] < side_q[2]) ? AXIS_X : AXIS_Z;
		end else begin
			step_ax = (side_q[1] < side_q[2]) ? AXIS_Y : AXIS_Z;
		end
	end

	always_comb begin
		case (cmd.op)
			OP_MUL_SQ: begin
				mul_a = MUL_W'(dmag_q[cmd.axis]);
				mul_b = MUL_W'(dmag_q[cmd.axis]);
			end
			OP_MUL_SIDE: begin
				mul_a = MUL_W'(frac_sel);
				mul_b = delta_q[cmd.axis];
			end
			OP_MUL_HP: begin
				mul_a = MUL_W'(q_q[cmd.axis]);
				mul_b = trav_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_go  = (cmd.op == OP_DIVQ_GO) || (cmd.op == OP_DIVD_GO);
	assign div_num = (cmd.op == OP_DIVQ_GO)
		? ((DIV_NW'(dmag_q[cmd.axis]) << (FRAC + 8)) + DIV_NW'(len_q >> 1))
		: (DIV_NW'(1) << (2 * FRAC));
	assign div_den = (cmd.op == OP_DIVQ_GO) ? DIV_DW'(len_q) : DIV_DW'(q_q[cmd.axis]);

	vgrt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	vgrt_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.op == OP_SQRT_GO),
		.val    ({sq_q, 16'd0}),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// The dropped fraction is rounded toward minus infinity for either sign of the direction component.
	always_comb begin
		if (dpos_q[cmd.axis]) begin
			hp_sh  = (FRAC+10)'((prod_q + PROD_W'((1 << FRAC) - 1)) >> FRAC);
			hp_sum = (POS_W+3)'(org_q[cmd.axis]) - $signed({1'b0, hp_sh});
		end else begin
			hp_sh  = (FRAC+10)'(prod_q >> FRAC);
			hp_sum = (POS_W+3)'(org_q[cmd.axis]) + $signed({1'b0, hp_sh});
		end
		if (hp_sum > SAT_HI) begin
			hp_val = POS_W'(SAT_HI);
		end else if (hp_sum < SAT_LO) begin
			hp_val = POS_W'(SAT_LO);
		end else begin
			hp_val = hp_sum[POS_W-1:0];
		end
	end

	assign side_sp = prod_q[FRAC+DIST_W:FRAC];

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			OP_LOAD: begin
				sq_q   <= '0;
				trav_q <= '0;
				for (int i = 0; i < 3; i++) begin
					org_q[i]  <= org_in[i];
					dpos_q[i] <= dir_in[i] > 0;
					dneg_q[i] <= dir_in[i] < 0;
					dmag_q[i] <= dir_in[i][DIR_W-1] ? DIR_W'(-dir_in[i]) : DIR_W'(dir_in[i]);
					vox_q[i]  <= VOX_W'(org_in[i] >>> FRAC);
				end
			end
			OP_ACC_SQ: begin
				sq_q <= sq_q + prod_q[SQ_W-1:0];
			end
			OP_SET_LEN: begin
				len_q <= sqrt_root;
			end
			OP_SET_Q: begin
				if (div_quo > DIV_NW'(ONE)) begin
					q_q[cmd.axis] <= ONE;
				end else begin
					q_q[cmd.axis] <= div_quo[Q_W-1:0];
				end
				npos_q[cmd.axis] <= dneg_q[cmd.axis] && (div_quo != '0);
				if (div_quo == '0) begin
					delta_q[cmd.axis] <= DMAX;
					side_q[cmd.axis]  <= DMAX;
				end
			end
			OP_SET_D: begin
				delta_q[cmd.axis] <= (div_quo > DIV_NW'(DMAX)) ? DMAX : div_quo[DIST_W-1:0];
			end
			OP_SET_SIDE: begin
				side_q[cmd.axis] <= side_sp[DIST_W] ? DMAX : side_sp[DIST_W-1:0];
			end
			OP_STEP: begin
				last_ax_q <= step_ax;
				trav_q    <= side_q[step_ax];
				for (int i = 0; i < 3; i++) begin
					if (axis_t'(i) == step_ax) begin
						vox_q[i]  <= npos_q[i] ? (vox_q[i] + VOX_W'(1)) : (vox_q[i] - VOX_W'(1));
						side_q[i] <= ({1'b0, side_q[i]} + {1'b0, delta_q[i]} > {1'b0, DMAX})
							? DMAX : (side_q[i] + delta_q[i]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Result registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SET_HP: begin
				case (cmd.axis)
					AXIS_X:  hit_pos_x <= hp_val;
					AXIS_Y:  hit_pos_y <= hp_val;
					default: hit_pos_z <= hp_val;
				endcase
			end
			OP_OUT_HIT: begin
				hit      <= 1'b1;
				block_x  <= vox_q[0][4:0];
				block_y  <= vox_q[1][4:0];
				block_z  <= vox_q[2][4:0];
				distance <= trav_q;
				normal_x <= (last_ax_q == AXIS_X) ? (npos_q[0] ? -2'sd1 : 2'sd1) : 2'sd0;
				normal_y <= (last_ax_q == AXIS_Y) ? (npos_q[1] ? -2'sd1 : 2'sd1) : 2'sd0;
				normal_z <= (last_ax_q == AXIS_Z) ? (npos_q[2] ? -2'sd1 : 2'sd1) : 2'sd0;
			end
			OP_OUT_MISS, OP_WRITE: begin
				hit       <= 1'b0;
				block_x   <= '0;
				block_y   <= '0;
				block_z   <= '0;
				distance  <= '0;
				normal_x  <= '0;
				normal_y  <= '0;
				normal_z  <= '0;
				hit_pos_x <= '0;
				hit_pos_y <= '0;
				hit_pos_z <= '0;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		st.sq_zero   = (sq_q == '0);
		st.sqrt_done = sqrt_done;
		st.div_done  = div_done;
		st.quo_zero  = (div_quo == '0);
		st.clr_last  = &clr_q;
		st.reached   = (trav_q >= max_q);
		st.solid     = rd_q && ingrid;
	end
endmodule
`default_nettype wire

[rtl/vgrt_ctrl.sv]
`default_nettype none
module vgrt_ctrl
	import vgrt_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    req_type,
	input  wire status_t st,
	output logic         busy,
	output logic         done,
	output cmd_t         cmd
);
	state_t state_q, state_d;
	axis_t  axis_q, axis_d;
	logic   done_q, done_d;
	logic   last_ax;

	assign last_ax = (axis_q == AXIS_Z);

	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		case (state_q)
			ST_CLEAR: begin
				if (st.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start && (req_type == REQ_CAST)) begin
					state_d = ST_SQ_MUL;
					axis_d  = AXIS_X;
				end
			end
			ST_SQ_MUL: state_d = ST_SQ_ACC;
			ST_SQ_ACC: begin
				if (last_ax) begin
					state_d = ST_ZCHK;
				end else begin
					state_d = ST_SQ_MUL;
					axis_d  = axis_q + axis_t'(1);
				end
			end
			ST_ZCHK: state_d = st.sq_zero ? ST_MISS : ST_SQRT_GO;
			ST_SQRT_GO: state_d = ST_SQRT_RUN;
			ST_SQRT_RUN: begin
				if (st.sqrt_done) begin
					state_d = ST_DQ_GO;
					axis_d  = AXIS_X;
				end
			end
			ST_DQ_GO: state_d = ST_DQ_RUN;
			ST_DQ_RUN: begin
				if (st.div_done) begin
					if (!st.quo_zero) begin
						state_d = ST_DD_GO;
					end else if (last_ax) begin
						state_d = ST_T0;
					end else begin
						state_d = ST_DQ_GO;
						axis_d  = axis_q + axis_t'(1);
					end
				end
			end
			ST_DD_GO: state_d = ST_DD_RUN;
			ST_DD_RUN: begin
				if (st.div_done) state_d = ST_SIDE_MUL;
			end
			ST_SIDE_MUL: state_d = ST_SIDE_SET;
			ST_SIDE_SET: begin
				if (last_ax) begin
					state_d = ST_T0;
				end else begin
					state_d = ST_DQ_GO;
					axis_d  = axis_q + axis_t'(1);
				end
			end
			ST_T0: state_d = st.reached ? ST_MISS : ST_STEP;
			ST_STEP: state_d = ST_RD;
			ST_RD: state_d = ST_TST;
			ST_TST: begin
				if (st.reached) begin
					state_d = ST_MISS;
				end else if (st.solid) begin
					state_d = ST_HP_MUL;
					axis_d  = AXIS_X;
				end else begin
					state_d = ST_STEP;
				end
			end
			ST_HP_MUL: state_d = ST_HP_ADD;
			ST_HP_ADD: begin
				if (last_ax) begin
					state_d = ST_HIT;
				end else begin
					state_d = ST_HP_MUL;
					axis_d  = axis_q + axis_t'(1);
				end
			end
			ST_HIT: state_d = ST_IDLE;
			ST_MISS: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.axis = axis_q;
		cmd.op   = OP_NONE;
		done_d   = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.op = OP_CLEAR;
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_CAST) begin
						cmd.op = OP_LOAD;
					end else begin
						cmd.op = OP_WRITE;
						done_d = 1'b1;
					end
				end
			end
			ST_SQ_MUL:   cmd.op = OP_MUL_SQ;
			ST_SQ_ACC:   cmd.op = OP_ACC_SQ;
			ST_SQRT_GO:  cmd.op = OP_SQRT_GO;
			ST_SQRT_RUN: cmd.op = st.sqrt_done ? OP_SET_LEN : OP_NONE;
			ST_DQ_GO:    cmd.op = OP_DIVQ_GO;
			ST_DQ_RUN:   cmd.op = st.div_done ? OP_SET_Q : OP_NONE;
			ST_DD_GO:    cmd.op = OP_DIVD_GO;
			ST_DD_RUN:   cmd.op = st.div_done ? OP_SET_D : OP_NONE;
			ST_SIDE_MUL: cmd.op = OP_MUL_SIDE;
			ST_SIDE_SET: cmd.op = OP_SET_SIDE;
			ST_STEP:     cmd.op = OP_STEP;
			ST_HP_MUL:   cmd.op = OP_MUL_HP;
			ST_HP_ADD:   cmd.op = OP_SET_HP;
			ST_HIT: begin
				cmd.op = OP_OUT_HIT;
				done_d = 1'b1;
			end
			ST_MISS: begin
				cmd.op = OP_OUT_MISS;
				done_d = 1'b1;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			axis_q  <= AXIS_X;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
endmodule
`default_nettype wire
